### src/lctg_pkg.sv
// ----------------------------------------------------------------------------
// lctg_pkg
// Shared types, constants and tables for the light controlled tone generator.
// ----------------------------------------------------------------------------
package lctg_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int FREQ_W     = 11;
	localparam int VOL_W      = 7;
	localparam int PERIOD_W   = 16;
	localparam int CLK_W      = 20;
	localparam int POS_W      = 5;
	localparam int MULT_W     = 2;
	localparam int HZ_W       = 10;
	localparam int DIV_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int TUNE_LEN   = 28;
	localparam int SONG_LENGTH_DEF = 28;

	localparam logic [FREQ_W-1:0]   FREQ_MAX     = 11'd2047;
	localparam logic [FREQ_W-1:0]   PCT_DIVISOR  = 11'd100;
	localparam logic [FREQ_W-1:0]   FREQ_RST     = 11'd800;
	localparam logic [VOL_W-1:0]    VOL_RST      = 7'd90;
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd311;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;

	localparam logic [VOL_W-1:0] VOL_ONE   = 7'd1;
	localparam logic [VOL_W-1:0] VOL_FIVE  = 7'd5;
	localparam logic [VOL_W-1:0] VOL_TEN   = 7'd10;
	localparam logic [VOL_W-1:0] VOL_QUART = 7'd25;
	localparam logic [VOL_W-1:0] VOL_HALF  = 7'd50;

	localparam logic [SAMPLE_W-1:0] PITCH_LOW_RST  = 12'd190;
	localparam logic [SAMPLE_W-1:0] PITCH_MID_RST  = 12'd300;
	localparam logic [SAMPLE_W-1:0] PITCH_HIGH_RST = 12'd450;
	localparam logic [SAMPLE_W-1:0] VOL_E1_RST     = 12'd1050;
	localparam logic [SAMPLE_W-1:0] VOL_E2_RST     = 12'd1200;
	localparam logic [SAMPLE_W-1:0] VOL_E3_RST     = 12'd1500;
	localparam logic [SAMPLE_W-1:0] VOL_E4_RST     = 12'd2500;
	localparam logic [CLK_W-1:0]    PWM_CLOCK_RST  = 20'd250000;

	typedef enum logic [1:0] {
		OP_PITCH  = 2'd0,
		OP_VOLUME = 2'd1,
		OP_TICK   = 2'd2,
		OP_BUTTON = 2'd3
	} lctg_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PITCH_LOW  = 3'd0,
		CFG_PITCH_MID  = 3'd1,
		CFG_PITCH_HIGH = 3'd2,
		CFG_VOL_E1     = 3'd3,
		CFG_VOL_E2     = 3'd4,
		CFG_VOL_E3     = 3'd5,
		CFG_VOL_E4     = 3'd6,
		CFG_PWM_CLOCK  = 3'd7
	} lctg_cfg_idx_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [SAMPLE_W-1:0] sample;
	} lctg_in_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] pwm_period;
		logic [PERIOD_W-1:0] pwm_compare;
		logic                song_mode;
	} lctg_out_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [FREQ_W-1:0] divisor;
	} lctg_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} lctg_div_rsp_t;

	localparam logic [3:0] TUNE [TUNE_LEN] = '{
		4'd1, 4'd1, 4'd2, 4'd1, 4'd4, 4'd3, 4'd9, 4'd1, 4'd1, 4'd2, 4'd1, 4'd5, 4'd4, 4'd9,
		4'd1, 4'd1, 4'd8, 4'd6, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd8, 4'd6, 4'd4, 4'd5, 4'd4
	};

	function automatic logic [HZ_W-1:0] note_hz(input logic [3:0] code);
		logic [HZ_W-1:0] hz;
		case (code)
			4'd1:    hz = 10'd261;
			4'd2:    hz = 10'd293;
			4'd3:    hz = 10'd329;
			4'd4:    hz = 10'd349;
			4'd5:    hz = 10'd392;
			4'd6:    hz = 10'd440;
			4'd7:    hz = 10'd494;
			4'd8:    hz = 10'd523;
			default: hz = 10'd0;
		endcase
		return hz;
	endfunction

	function automatic logic [HZ_W-1:0] tune_hz(input logic [POS_W-1:0] pos);
		logic [HZ_W-1:0] hz;
		hz = '0;
		if (pos < POS_W'(TUNE_LEN)) begin
			hz = note_hz(TUNE[pos]);
		end
		return hz;
	endfunction

endpackage

### src/lctg_div.sv
// ----------------------------------------------------------------------------
// lctg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lctg_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lctg_pkg::lctg_div_req_t req,
	output lctg_pkg::lctg_div_rsp_t rsp
);
	import lctg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  acc_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dvsr_q;

	logic [FREQ_W:0]   rem_sh;
	logic [FREQ_W+1:0] diff;
	logic              qbit;
	logic [FREQ_W-1:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, acc_q[DIV_W-1]};
		diff     = {1'b0, rem_sh} - {2'b00, dvsr_q};
		qbit     = !diff[FREQ_W+1];
		rem_next = qbit ? diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = acc_q;

endmodule

### src/light_controlled_tone_generator_top.sv
// ----------------------------------------------------------------------------
// light_controlled_tone_generator_top
// Sensor driven tone generator: PWM period and compare from light readings.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one event per transfer:
//   a pitch sample, a volume sample, a note tick or a button press.
//   result channel (result_valid/result_ready/result) returns one transfer
//   per event: PWM period, compare value and the song mode flag.
//   cfg_we/cfg_index/cfg_wdata write the thresholds and PWM clock; write
//   only while the block is idle.
//   All divisions go through one shared 24-step restoring divider, run up
//   to three times per event (square over 100, clock over frequency,
//   volume times period over 100). A volume sample, a tick in theremin
//   mode or a button press takes only the compare division, a tick in song
//   mode or a song mode pitch sample adds the period division, and a
//   theremin pitch sample adds the square division; a division is skipped
//   for a zero frequency or period. item_ready is low while an event is in
//   work and returns when the result is registered, so a new event is
//   accepted only after the last one is done.
//   A stalled result holds in the output register; the next event may be
//   accepted meanwhile, but its result holds until the receiver takes it.
//   Reset: theremin mode, 800 Hz, 90 percent volume, period 311, defaults.
// ----------------------------------------------------------------------------
module light_controlled_tone_generator_top #(
	parameter int SONG_LENGTH = lctg_pkg::SONG_LENGTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  lctg_pkg::lctg_in_t                    item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output lctg_pkg::lctg_out_t                   result,
	input  logic                                  cfg_we,
	input  logic [lctg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lctg_pkg::CLK_W-1:0]            cfg_wdata
);
	import lctg_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EXEC = 9'b000000010,
		S_SQR  = 9'b000000100,
		S_WSQR = 9'b000001000,
		S_PER  = 9'b000010000,
		S_WPER = 9'b000100000,
		S_CMP  = 9'b001000000,
		S_WCMP = 9'b010000000,
		S_DONE = 9'b100000000
	} lctg_state_t;

	lctg_state_t state_q;

	logic [SAMPLE_W-1:0] pitch_low_q, pitch_mid_q, pitch_high_q;
	logic [SAMPLE_W-1:0] vol_e1_q, vol_e2_q, vol_e3_q, vol_e4_q;
	logic [CLK_W-1:0]    pwm_clock_q;

	logic                mode_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [VOL_W-1:0]    vol_q;
	logic [MULT_W-1:0]   mult_q;
	logic [POS_W-1:0]    pos_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] compare_q;

	lctg_in_t            item_q;
	logic [SAMPLE_W-1:0] base_q;
	logic                result_valid_q;
	lctg_out_t           result_q;
	logic                res_load;

	lctg_div_req_t div_req;
	lctg_div_rsp_t div_rsp;

	logic [SAMPLE_W-1:0]    clamped;
	logic [HZ_W+MULT_W-1:0] song_freq;
	logic [DIV_W-1:0]       quo;

	lctg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign quo      = div_rsp.quotient;
	assign res_load = (state_q == S_DONE) && (!result_valid_q || result_ready);

	always_comb begin
		if (item_q.sample < pitch_low_q) begin
			clamped = pitch_low_q;
		end else if (item_q.sample > pitch_high_q) begin
			clamped = pitch_high_q;
		end else begin
			clamped = item_q.sample;
		end
		song_freq = tune_hz(pos_q) * mult_q;
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = PCT_DIVISOR;
		unique case (state_q)
			S_SQR: begin
				div_req.start    = 1'b1;
				div_req.dividend = base_q * base_q;
			end
			S_PER: begin
				div_req.start    = (freq_q != '0);
				div_req.dividend = DIV_W'(pwm_clock_q);
				div_req.divisor  = freq_q;
			end
			S_CMP: begin
				div_req.start    = (period_q != '0);
				div_req.dividend = DIV_W'(vol_q) * DIV_W'(period_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_low_q  <= PITCH_LOW_RST;
			pitch_mid_q  <= PITCH_MID_RST;
			pitch_high_q <= PITCH_HIGH_RST;
			vol_e1_q     <= VOL_E1_RST;
			vol_e2_q     <= VOL_E2_RST;
			vol_e3_q     <= VOL_E3_RST;
			vol_e4_q     <= VOL_E4_RST;
			pwm_clock_q  <= PWM_CLOCK_RST;
		end else if (cfg_we) begin
			unique case (lctg_cfg_idx_t'(cfg_index))
				CFG_PITCH_LOW:  pitch_low_q  <= cfg_wdata[SAMPLE_W-1:0];
				CFG_PITCH_MID:  pitch_mid_q  <= cfg_wdata[SAMPLE_W-1:0];
				CFG_PITCH_HIGH: pitch_high_q <= cfg_wdata[SAMPLE_W-1:0];
				CFG_VOL_E1:     vol_e1_q     <= cfg_wdata[SAMPLE_W-1:0];
				CFG_VOL_E2:     vol_e2_q     <= cfg_wdata[SAMPLE_W-1:0];
				CFG_VOL_E3:     vol_e3_q     <= cfg_wdata[SAMPLE_W-1:0];
				CFG_VOL_E4:     vol_e4_q     <= cfg_wdata[SAMPLE_W-1:0];
				CFG_PWM_CLOCK:  pwm_clock_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (state_q == S_EXEC) begin
			base_q <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= 1'b0;
			freq_q         <= FREQ_RST;
			vol_q          <= VOL_RST;
			mult_q         <= '0;
			pos_q          <= '0;
			period_q       <= PERIOD_RST;
			compare_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (lctg_op_t'(item_q.operation))
						OP_PITCH: begin
							if (mode_q) begin
								if (item_q.sample < pitch_low_q) begin
									mult_q <= 2'd1;
								end else if (item_q.sample < pitch_mid_q) begin
									mult_q <= 2'd2;
								end else begin
									mult_q <= 2'd3;
								end
								state_q <= S_PER;
							end else begin
								state_q <= S_SQR;
							end
						end
						OP_VOLUME: begin
							if (item_q.sample < vol_e1_q) begin
								vol_q <= VOL_ONE;
							end else if (item_q.sample < vol_e2_q) begin
								vol_q <= VOL_FIVE;
							end else if (item_q.sample < vol_e3_q) begin
								vol_q <= VOL_TEN;
							end else if (item_q.sample < vol_e4_q) begin
								vol_q <= VOL_QUART;
							end else begin
								vol_q <= VOL_HALF;
							end
							state_q <= S_CMP;
						end
						OP_TICK: begin
							if (!mode_q) begin
								pos_q   <= '0;
								state_q <= S_CMP;
							end else begin
								if (pos_q < POS_W'(SONG_LENGTH)) begin
									freq_q <= song_freq[FREQ_W-1:0];
									pos_q  <= pos_q + 1'b1;
								end else begin
									freq_q <= '0;
									pos_q  <= '0;
								end
								state_q <= S_PER;
							end
						end
						default: begin
							mode_q  <= !mode_q;
							state_q <= S_CMP;
						end
					endcase
				end
				S_SQR: begin
					state_q <= S_WSQR;
				end
				S_WSQR: begin
					if (div_rsp.done) begin
						freq_q  <= (quo > DIV_W'(FREQ_MAX)) ? FREQ_MAX : quo[FREQ_W-1:0];
						state_q <= S_PER;
					end
				end
				S_PER: begin
					if (freq_q == '0) begin
						period_q <= '0;
						state_q  <= S_CMP;
					end else begin
						state_q <= S_WPER;
					end
				end
				S_WPER: begin
					if (div_rsp.done) begin
						if (quo == '0) begin
							period_q <= '0;
						end else if (quo > DIV_W'(PERIOD_MAX) + 1'b1) begin
							period_q <= PERIOD_MAX;
						end else begin
							period_q <= PERIOD_W'(quo - 1'b1);
						end
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (period_q == '0) begin
						compare_q <= '0;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_WCMP;
					end
				end
				S_WCMP: begin
					if (div_rsp.done) begin
						if (quo >= DIV_W'(period_q)) begin
							compare_q <= period_q - 1'b1;
						end else begin
							compare_q <= quo[PERIOD_W-1:0];
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						result_q.pwm_period  <= period_q;
						result_q.pwm_compare <= compare_q;
						result_q.song_mode   <= mode_q;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item_ready high right after a transfer");

	a_silent_compare: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pwm_period == '0 |-> result.pwm_compare == '0)
		else $error("nonzero compare with zero period");

	a_compare_below: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pwm_period != '0 |-> result.pwm_compare < result.pwm_period)
		else $error("compare not below period");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WSQR || state_q == S_WPER || state_q == S_WCMP))
		else $error("divider finished outside a wait state");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
`endif

endmodule
